/* src/mpba_pkg.sv */
// ----------------------------------------------------------------------------
// mpba_pkg
// Shared types and constants of the multi-pool block allocator.
// ----------------------------------------------------------------------------
package mpba_pkg;

    localparam int CFG_POOLS  = 4;
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 9;
    localparam int IDX_W      = 8;
    localparam int POOL_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int HEAD_W     = 9;
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // list head value of an empty free list
    localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(256);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    // register map: sizes first, then counts
    localparam logic [2:0] REG_SIZE_BASE  = 3'd0;
    localparam logic [2:0] REG_COUNT_BASE = 3'd4;

    typedef struct packed {
        logic [CFG_POOLS-1:0][SIZE_W-1:0]  size;
        logic [CFG_POOLS-1:0][COUNT_W-1:0] count;
    } cfg_t;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [POOL_W-1:0] fpool;
        logic [IDX_W-1:0]  findex;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POOL_W-1:0]   pool;
        logic [IDX_W-1:0]    index;
        logic                pop;     // grant taken from a free list, head update pending
    } decision_t;

endpackage

/* src/mpba_cfg.sv */
// ----------------------------------------------------------------------------
// mpba_cfg
// APB register file holding the block size and block count of each pool.
// ----------------------------------------------------------------------------
module mpba_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpba_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mpba_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mpba_pkg::APB_DATA_W-1:0] prdata,
    output mpba_pkg::cfg_t                  cfg
);
    import mpba_pkg::*;

    logic [SIZE_W-1:0]  size_reg  [CFG_POOLS];
    logic [COUNT_W-1:0] count_reg [CFG_POOLS];
    logic [2:0]         reg_idx;
    logic               wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < CFG_POOLS; p++) begin
                size_reg[p]  <= '0;
                count_reg[p] <= '0;
            end
        end else if (wr_en) begin
            if (reg_idx < REG_COUNT_BASE) begin
                size_reg[reg_idx[1:0]] <= pwdata[SIZE_W-1:0];
            end else begin
                count_reg[reg_idx[1:0]] <= pwdata[COUNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx < REG_COUNT_BASE) begin
            prdata = APB_DATA_W'(size_reg[reg_idx[1:0]]);
        end else begin
            prdata = APB_DATA_W'(count_reg[reg_idx[1:0]]);
        end
    end

    always_comb begin
        for (int p = 0; p < CFG_POOLS; p++) begin
            cfg.size[p]  = size_reg[p];
            cfg.count[p] = count_reg[p];
        end
    end

endmodule

/* src/mpba_link_mem.sv */
// ----------------------------------------------------------------------------
// mpba_link_mem
// Next-link RAM of the free lists: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mpba_link_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [mpba_pkg::IDX_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [mpba_pkg::IDX_W-1:0] rdata
);
    import mpba_pkg::*;

    logic [IDX_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/mpba_pool_ctrl.sv */
// ----------------------------------------------------------------------------
// mpba_pool_ctrl
// Per-pool list heads and high-water marks, pool search, and the
// read-modify-write of the next-link RAM.
// ----------------------------------------------------------------------------
module mpba_pool_ctrl #(
    parameter int NUM_POOLS       = 4,
    parameter int BLOCKS_PER_POOL = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mpba_pkg::cfg_t      cfg,
    input  mpba_pkg::item_t     item,
    input  logic                exec_fire,
    input  logic                pop_fire,
    output mpba_pkg::decision_t dec
);
    import mpba_pkg::*;

    localparam int ACT_POOLS = (NUM_POOLS < CFG_POOLS) ? NUM_POOLS : CFG_POOLS;
    localparam int BLK       = (BLOCKS_PER_POOL < 256) ? BLOCKS_PER_POOL : 256;
    localparam int MEM_DEPTH = ACT_POOLS * BLK;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [COUNT_W-1:0] BLK_CNT  = COUNT_W'(BLK);
    localparam logic [MEM_AW-1:0]  BLK_ADDR = MEM_AW'(BLK);

    logic [HEAD_W-1:0]  head_reg  [ACT_POOLS];
    logic [HEAD_W-1:0]  head_next [ACT_POOLS];
    logic [HEAD_W-1:0]  mark_reg  [ACT_POOLS];
    logic [HEAD_W-1:0]  mark_next [ACT_POOLS];
    logic [COUNT_W-1:0] usable    [ACT_POOLS];

    logic              found;
    logic              stop;
    logic [POOL_W-1:0] sel_pool;
    logic [HEAD_W-1:0] sel_head;
    logic [HEAD_W-1:0] sel_mark;
    logic              sel_from_list;

    logic              free_ok;
    logic [HEAD_W-1:0] fr_head;

    logic [POOL_W-1:0] pop_pool_reg;
    logic [IDX_W-1:0]  pop_head_reg;

    logic              mem_we;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_waddr;
    logic [MEM_AW-1:0] mem_raddr;
    logic [IDX_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]  mem_rdata;

    function automatic logic [MEM_AW-1:0] link_addr(input logic [POOL_W-1:0] pool,
                                                    input logic [IDX_W-1:0]  idx);
        return MEM_AW'(pool) * BLK_ADDR + MEM_AW'(idx);
    endfunction

    always_comb begin
        for (int p = 0; p < ACT_POOLS; p++) begin
            usable[p] = (cfg.count[p] > BLK_CNT) ? BLK_CNT : cfg.count[p];
        end
    end

    // first fitting pool with a block left; an unused pool ends the search
    always_comb begin
        found    = 1'b0;
        stop     = 1'b0;
        sel_pool = '0;
        sel_head = EMPTY_MARK;
        sel_mark = '0;
        for (int p = 0; p < ACT_POOLS; p++) begin
            if (!found && !stop) begin
                if (cfg.size[p] == '0) begin
                    stop = 1'b1;
                end else if (cfg.size[p] >= item.size &&
                             (head_reg[p] != EMPTY_MARK || mark_reg[p] < usable[p])) begin
                    found    = 1'b1;
                    sel_pool = POOL_W'(p);
                    sel_head = head_reg[p];
                    sel_mark = mark_reg[p];
                end
            end
        end
        sel_from_list = (sel_head != EMPTY_MARK);
    end

    // a free is valid only for a used pool and a block already handed out
    always_comb begin
        free_ok = 1'b0;
        fr_head = EMPTY_MARK;
        for (int p = 0; p < ACT_POOLS; p++) begin
            if (POOL_W'(p) == item.fpool) begin
                fr_head = head_reg[p];
                free_ok = (cfg.size[p] != '0) &&
                          (COUNT_W'(item.findex) < usable[p]) &&
                          (HEAD_W'(item.findex) < mark_reg[p]);
            end
        end
    end

    always_comb begin
        dec = '0;
        if (item.op == OP_ALLOC) begin
            if (found) begin
                dec.pool  = sel_pool;
                dec.index = sel_from_list ? sel_head[IDX_W-1:0] : sel_mark[IDX_W-1:0];
                dec.pop   = sel_from_list;
            end else begin
                dec.status = STATUS_NO_FIT;
            end
        end else if (!free_ok) begin
            dec.status = STATUS_BAD_FREE;
        end
    end

    always_comb begin
        for (int p = 0; p < ACT_POOLS; p++) begin
            head_next[p] = head_reg[p];
            mark_next[p] = mark_reg[p];
        end
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = link_addr(sel_pool, sel_head[IDX_W-1:0]);
        mem_waddr = link_addr(item.fpool, item.findex);
        mem_wdata = (fr_head == EMPTY_MARK) ? item.findex : fr_head[IDX_W-1:0];

        // link read back: a self-link ends the list
        if (pop_fire) begin
            for (int p = 0; p < ACT_POOLS; p++) begin
                if (POOL_W'(p) == pop_pool_reg) begin
                    head_next[p] = (mem_rdata == pop_head_reg) ?
                                   EMPTY_MARK : HEAD_W'(mem_rdata);
                end
            end
        end

        if (exec_fire) begin
            if (item.op == OP_ALLOC) begin
                if (found && sel_from_list) begin
                    mem_re = 1'b1;
                end else if (found) begin
                    for (int p = 0; p < ACT_POOLS; p++) begin
                        if (POOL_W'(p) == sel_pool) begin
                            mark_next[p] = sel_mark + 1'b1;
                        end
                    end
                end
            end else if (free_ok) begin
                mem_we = 1'b1;
                for (int p = 0; p < ACT_POOLS; p++) begin
                    if (POOL_W'(p) == item.fpool) begin
                        head_next[p] = HEAD_W'(item.findex);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < ACT_POOLS; p++) begin
                head_reg[p] <= EMPTY_MARK;
                mark_reg[p] <= '0;
            end
        end else begin
            for (int p = 0; p < ACT_POOLS; p++) begin
                head_reg[p] <= head_next[p];
                mark_reg[p] <= mark_next[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            pop_pool_reg <= sel_pool;
            pop_head_reg <= sel_head[IDX_W-1:0];
        end
    end

    mpba_link_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_link_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

/* src/multi_pool_block_allocator.sv */
// ----------------------------------------------------------------------------
// multi_pool_block_allocator
// Fixed-size block allocator over up to four pools with LIFO free lists.
//
//   channel   ports            beat
//   input     s_*              op, request_size, freed_pool, freed_index
//   result    m_*              status, granted_pool, granted_index
//   config    APB (p*)         pool block sizes and block counts
//
// A new beat is taken as the last executes unless the result stalls; a free-list
// allocate holds it back, as the next-link read must land before the head moves.
// Synchronous active-low reset; no clearing pass, link RAM is written before
// it is read. A stalled result register holds the pending beat and blocks
// only the following one; the input is taken while a result waits.
// ----------------------------------------------------------------------------
module multi_pool_block_allocator #(
    parameter int NUM_POOLS       = 4,
    parameter int BLOCKS_PER_POOL = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpba_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mpba_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mpba_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [mpba_pkg::SIZE_W-1:0]     s_request_size,
    input  logic [mpba_pkg::POOL_W-1:0]     s_freed_pool,
    input  logic [mpba_pkg::IDX_W-1:0]      s_freed_index,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mpba_pkg::STATUS_W-1:0]   m_status,
    output logic [mpba_pkg::POOL_W-1:0]     m_granted_pool,
    output logic [mpba_pkg::IDX_W-1:0]      m_granted_index
);
    import mpba_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    item_t               item_reg;
    cfg_t                cfg;
    decision_t           dec;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [POOL_W-1:0]   m_pool_reg;
    logic [IDX_W-1:0]    m_index_reg;

    logic                out_free;
    logic                exec_fire;
    logic                pop_fire;
    logic                s_fire;

    assign pready    = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;
    assign pop_fire  = (state_reg == ST_POP);
    assign s_ready   = (state_reg == ST_IDLE) || (state_reg == ST_POP) ||
                       (exec_fire && !dec.pop);
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        priority if (s_fire) begin
            state_next = ST_EXEC;
        end else if (exec_fire && dec.pop) begin
            state_next = ST_POP;
        end else if (exec_fire || pop_fire) begin
            state_next = ST_IDLE;
        end else begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.op     <= s_op;
            item_reg.size   <= s_request_size;
            item_reg.fpool  <= s_freed_pool;
            item_reg.findex <= s_freed_index;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_status_reg <= dec.status;
            m_pool_reg   <= dec.pool;
            m_index_reg  <= dec.index;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_pool  = m_pool_reg;
    assign m_granted_index = m_index_reg;

    mpba_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mpba_pool_ctrl #(
        .NUM_POOLS       (NUM_POOLS),
        .BLOCKS_PER_POOL (BLOCKS_PER_POOL)
    ) u_pool_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .item      (item_reg),
        .exec_fire (exec_fire),
        .pop_fire  (pop_fire),
        .dec       (dec)
    );

endmodule

/* src/mpba_checker.sv */
// ----------------------------------------------------------------------------
// mpba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module mpba_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mpba_pkg::STATUS_W-1:0] m_status,
    input logic [mpba_pkg::POOL_W-1:0]   m_granted_pool,
    input logic [mpba_pkg::IDX_W-1:0]    m_granted_index
);
    import mpba_pkg::*;

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
                                $stable(m_granted_pool) && $stable(m_granted_index))
        else $error("result beat changed while stalled");

    // failed requests grant nothing
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_granted_pool == '0 && m_granted_index == '0)
        else $error("error result carries a grant");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == STATUS_OK || m_status == STATUS_NO_FIT ||
                    m_status == STATUS_BAD_FREE)
        else $error("undefined status code");

    // an accepted beat reaches the result register when it is free in the cycle after acceptance
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 (!m_valid || m_ready) |=> m_valid)
        else $error("accepted beat produced no result");

endmodule

bind multi_pool_block_allocator mpba_checker u_mpba_checker (.*);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_pool_block_allocator. A built-in allocator
// model tracks free lists, high-water marks and pool setup, predicts every
// result beat and compares it field by field. Directed checks (no setup, pool
// search, setup change) come first, then random alloc/free traffic over several
// pool setups, with random idle cycles on both channels except in the last run.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mpba_pkg::*;

    localparam int NUM_POOLS       = 4;
    localparam int BLOCKS_PER_POOL = 256;
    localparam int ACTIVE_POOLS    = (NUM_POOLS < CFG_POOLS) ? NUM_POOLS : CFG_POOLS;
    localparam int USABLE_CAP      = (BLOCKS_PER_POOL < 256) ? BLOCKS_PER_POOL : 256;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POOL_W-1:0]   pool;
        logic [IDX_W-1:0]    index;
    } grant_t;

    typedef struct {
        logic [POOL_W-1:0] pool;
        logic [IDX_W-1:0]  index;
    } handle_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_op           = OP_ALLOC;
    logic [SIZE_W-1:0]     s_request_size = '0;
    logic [POOL_W-1:0]     s_freed_pool   = '0;
    logic [IDX_W-1:0]      s_freed_index  = '0;

    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [POOL_W-1:0]     m_granted_pool;
    logic [IDX_W-1:0]      m_granted_index;

    // allocator model state
    logic [IDX_W-1:0]   link_of    [CFG_POOLS][256];
    logic [HEAD_W-1:0]  head_of    [CFG_POOLS];
    logic [HEAD_W-1:0]  high_water [CFG_POOLS];
    logic [SIZE_W-1:0]  blk_size   [CFG_POOLS];
    logic [COUNT_W-1:0] blk_count  [CFG_POOLS];

    grant_t  expected_grants[$];
    handle_t held_blocks[$];
    int      src_idle_pct = 0;
    int      dst_idle_pct = 0;
    int      fail_count   = 0;

    multi_pool_block_allocator #(
        .NUM_POOLS       (NUM_POOLS),
        .BLOCKS_PER_POOL (BLOCKS_PER_POOL)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_request_size  (s_request_size),
        .s_freed_pool    (s_freed_pool),
        .s_freed_index   (s_freed_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_pool  (m_granted_pool),
        .m_granted_index (m_granted_index)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int usable_blocks(input int p);
        int c;
        c = blk_count[p];
        if (c > USABLE_CAP) c = USABLE_CAP;
        return c;
    endfunction

    // advances the model by one request beat and returns the grant it yields
    function automatic grant_t predict_grant(input logic op, input logic [SIZE_W-1:0] sz,
                                             input logic [POOL_W-1:0] fp,
                                             input logic [IDX_W-1:0] fi);
        grant_t            res;
        logic              searching;
        logic [HEAD_W-1:0] hd;
        logic [IDX_W-1:0]  nx;
        res = '{STATUS_OK, '0, '0};
        if (op == OP_ALLOC) begin
            res.status = STATUS_NO_FIT;
            searching  = 1'b1;
            for (int p = 0; p < ACTIVE_POOLS; p++) begin
                // an unused pool ends the search
                if (searching && blk_size[p] == '0) searching = 1'b0;
                if (searching && blk_size[p] >= sz) begin
                    hd = head_of[p];
                    if (hd != EMPTY_MARK) begin
                        nx = link_of[p][hd[IDX_W-1:0]];
                        head_of[p] = (HEAD_W'(nx) == hd) ? EMPTY_MARK : HEAD_W'(nx);
                        res = '{STATUS_OK, POOL_W'(p), hd[IDX_W-1:0]};
                        searching = 1'b0;
                    end else if (int'(high_water[p]) < usable_blocks(p)) begin
                        res = '{STATUS_OK, POOL_W'(p), high_water[p][IDX_W-1:0]};
                        high_water[p] = high_water[p] + 1'b1;
                        searching = 1'b0;
                    end
                end
            end
        end else if (int'(fp) >= ACTIVE_POOLS || blk_size[fp] == '0 ||
                     int'(fi) >= usable_blocks(fp) || HEAD_W'(fi) >= high_water[fp]) begin
            res.status = STATUS_BAD_FREE;
        end else begin
            // a block that links to itself ends its list
            link_of[fp][fi] = (head_of[fp] == EMPTY_MARK) ? fi : head_of[fp][IDX_W-1:0];
            head_of[fp] = HEAD_W'(fi);
        end
        return res;
    endfunction

    task automatic send_item(input logic op, input logic [SIZE_W-1:0] sz,
                             input logic [POOL_W-1:0] fp, input logic [IDX_W-1:0] fi);
        grant_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_request_size <= sz;
        s_freed_pool   <= fp;
        s_freed_index  <= fi;
        do @(posedge aclk); while (!s_ready);
        res = predict_grant(op, sz, fp, fi);
        expected_grants.push_back(res);
        if (op == OP_ALLOC && res.status == STATUS_OK)
            held_blocks.push_back('{res.pool, res.index});
    endtask

    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input int idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < int'(REG_COUNT_BASE)) blk_size[idx] = SIZE_W'(value);
        else blk_count[idx - int'(REG_COUNT_BASE)] = COUNT_W'(value);
        @(posedge aclk);
    endtask

    task automatic write_pool(input int p, input int sz, input int cnt);
        write_reg(int'(REG_SIZE_BASE) + p, sz);
        write_reg(int'(REG_COUNT_BASE) + p, cnt);
    endtask

    // nothing configured: every alloc misses, every free is rejected
    task automatic test_unconfigured();
        send_item(OP_ALLOC, 16'd0, 2'd0, 8'd0);
        send_item(OP_ALLOC, 16'hFFFF, 2'd3, 8'hFF);
        send_item(OP_FREE, 16'd0, 2'd0, 8'd0);
        send_item(OP_FREE, 16'hFFFF, 2'd3, 8'hFF);
        wait_until_idle();
    endtask

    // pool 1 has no blocks and must be skipped, not end the search
    task automatic test_pool_search();
        write_pool(0, 16, 2);
        write_pool(1, 64, 0);
        write_pool(2, 256, 3);
        write_pool(3, 65535, 256);
        send_item(OP_ALLOC, 16'd0, 2'd0, 8'd0);
        send_item(OP_ALLOC, 16'd16, 2'd0, 8'd0);
        send_item(OP_ALLOC, 16'd16, 2'd0, 8'd0);
        send_item(OP_ALLOC, 16'hFFFF, 2'd0, 8'd0);
        send_item(OP_ALLOC, 16'hFFFF, 2'd0, 8'd0);
        send_item(OP_FREE, 16'd0, 2'd0, 8'd1);
        send_item(OP_FREE, 16'd0, 2'd0, 8'd1);      // double free of the head
        send_item(OP_ALLOC, 16'd10, 2'd0, 8'd0);
        send_item(OP_ALLOC, 16'd10, 2'd0, 8'd0);
        send_item(OP_FREE, 16'd0, 2'd1, 8'd0);      // pool without blocks
        send_item(OP_FREE, 16'd0, 2'd0, 8'd255);
        send_item(OP_FREE, 16'd0, 2'd3, 8'd1);
        send_item(OP_FREE, 16'd0, 2'd3, 8'd0);
        send_item(OP_FREE, 16'd0, 2'd3, 8'd2);      // never handed out
        send_item(OP_ALLOC, 16'd1000, 2'd0, 8'd0);
        send_item(OP_ALLOC, 16'd1000, 2'd0, 8'd0);
        send_item(OP_ALLOC, 16'd1000, 2'd0, 8'd0);
        wait_until_idle();
    endtask

    // setup changed while blocks are out; state is kept
    task automatic test_config_change();
        write_pool(1, 0, 0);
        write_pool(3, 65535, 1);
        send_item(OP_ALLOC, 16'd17, 2'd0, 8'd0);
        send_item(OP_FREE, 16'd0, 2'd2, 8'd0);
        send_item(OP_FREE, 16'd0, 2'd3, 8'd1);      // beyond the shrunk count
        send_item(OP_FREE, 16'd0, 2'd0, 8'd0);
        send_item(OP_ALLOC, 16'd0, 2'd0, 8'd0);
        wait_until_idle();
    endtask

    task automatic load_random_pools();
        int sz;
        int size_val;
        int cnt;
        sz = 0;
        for (int p = 0; p < CFG_POOLS; p++) begin
            sz = sz + $urandom_range(300);
            if (sz > 65535) sz = 65535;
            size_val = sz;
            if (p > 0 && $urandom_range(7) == 0) size_val = 0;
            if (p == CFG_POOLS - 1 && $urandom_range(3) == 0) size_val = 65535;
            cnt = ($urandom_range(7) == 0) ? 256 : $urandom_range(6);
            write_pool(p, size_val, cnt);
        end
    endtask

    task automatic run_alloc_free_mix(input int items);
        int               r;
        int               p;
        int               j;
        handle_t          h;
        logic [SIZE_W-1:0] sz;
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(99);
            if (r < 48) begin
                p = $urandom_range(CFG_POOLS - 1);
                case ($urandom_range(3))
                    0: begin
                        sz = blk_size[p];
                    end
                    1: begin
                        sz = blk_size[p] - SIZE_W'($urandom_range(8));
                    end
                    2: begin
                        sz = blk_size[p] + 1'b1;
                    end
                    default: begin
                        sz = SIZE_W'($urandom_range(64));
                    end
                endcase
                send_item(OP_ALLOC, sz, POOL_W'($urandom), IDX_W'($urandom));
            end else if (r < 90 && held_blocks.size() != 0) begin
                j = $urandom_range(held_blocks.size() - 1);
                h = held_blocks[j];
                // now and then keep the handle so it is freed twice
                if ($urandom_range(19) != 0) held_blocks.delete(j);
                send_item(OP_FREE, SIZE_W'($urandom), h.pool, h.index);
            end else begin
                send_item(1'($urandom), SIZE_W'($urandom), POOL_W'($urandom),
                          IDX_W'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic(input int src_pct, input int dst_pct);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        repeat (4) begin
            load_random_pools();
            run_alloc_free_mix(102);
            wait_until_idle();
        end
    endtask

    always @(posedge aclk) begin : result_check
        grant_t want;
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                $error("result beat with none expected: status %0d pool %0d index %0d",
                       m_status, m_granted_pool, m_granted_index);
                fail_count++;
            end else begin
                want = expected_grants.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_granted_pool !== want.pool) begin
                    $error("granted_pool: expected %0d, got %0d", want.pool, m_granted_pool);
                    fail_count++;
                end
                if (m_granted_index !== want.index) begin
                    $error("granted_index: expected %0d, got %0d",
                           want.index, m_granted_index);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int p = 0; p < CFG_POOLS; p++) begin
            head_of[p]    = EMPTY_MARK;
            high_water[p] = '0;
            blk_size[p]   = '0;
            blk_count[p]  = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct = 9;
        dst_idle_pct = 54;
        test_unconfigured();
        test_pool_search();
        test_config_change();
        test_random_traffic(9, 54);
        test_random_traffic(54, 9);
        test_random_traffic(0, 0);
        wait_until_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && expected_grants.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
